// File: sv/windowed_majority_input_qualifier_top_assert.svh
// Assertion macros used by the checker file.
`ifndef WINDOWED_MAJORITY_INPUT_QUALIFIER_TOP_ASSERT_SVH
`define WINDOWED_MAJORITY_INPUT_QUALIFIER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define WMIQ_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define WMIQ_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/wmiq_pkg.sv
`timescale 1ns / 1ps

package wmiq_pkg;

   localparam int COUNT_BITS  = 7;
   localparam int CFG_BITS    = 7;
   localparam int CMP_BITS    = (COUNT_BITS > CFG_BITS) ? COUNT_BITS : CFG_BITS;
   localparam int NUM_PINS    = 16;
   localparam int NUM_BYTES   = 3;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   // Register indexes of the configuration port.
   localparam logic [1:0] REG_WINDOW_LENGTH  = 2'd0;
   localparam logic [1:0] REG_ON_THRESHOLD   = 2'd1;
   localparam logic [1:0] REG_HALF_THRESHOLD = 2'd2;

   localparam logic [CFG_BITS-1:0] WINDOW_LENGTH_RESET  = CFG_BITS'(100);
   localparam logic [CFG_BITS-1:0] ON_THRESHOLD_RESET   = CFG_BITS'(60);
   localparam logic [CFG_BITS-1:0] HALF_THRESHOLD_RESET = CFG_BITS'(30);

   // Valve levels.
   localparam logic [1:0] LEVEL_OFF  = 2'd0;
   localparam logic [1:0] LEVEL_HALF = 2'd1;
   localparam logic [1:0] LEVEL_ON   = 2'd2;

   typedef struct packed {
      logic on;
      logic above_half;
   } lane_flags_type;

   typedef enum logic [1:0] {
      SLOT_0 = 2'd0,
      SLOT_1 = 2'd1,
      SLOT_2 = 2'd2
   } frame_slot_type;

endpackage

// File: sv/windowed_majority_input_qualifier_top.sv
`timescale 1ns / 1ps

// Windowed majority qualifier for sixteen input pins (A2-A7, B0-B5, C0-C3).
// Each accepted word is one sample of the three ports; sixteen counter
// lanes update in parallel, so a sample can be taken every cycle. The
// sample closing a window of window_length samples (zero acts as one)
// loads a three-byte status frame into the frame register, which sends
// one byte per cycle while rsp_stall is low. The closing sample stalls
// only while the previous frame is still draining, so without response
// stalls windows of three or more take one sample per cycle; shorter
// windows stall at each closing sample. Counters restart at once for the
// next window. Reset clears counters and frame state, sets configuration
// defaults; write the configuration registers only while the block is idle.
module windowed_majority_input_qualifier_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [7:0]                    req_port_a_sample,
   input  logic [7:0]                    req_port_b_sample,
   input  logic [7:0]                    req_port_c_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [7:0]                    rsp_frame_byte,
   output logic                          rsp_last_byte,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [1:0]                    csr_index,
   input  logic [wmiq_pkg::CFG_BITS-1:0] csr_data
);
   import wmiq_pkg::*;

   logic [CFG_BITS-1:0] window_length_ff;
   logic [CFG_BITS-1:0] on_threshold_ff;
   logic [CFG_BITS-1:0] half_threshold_ff;
   logic [CFG_BITS-1:0] samples_ff;
   logic [CFG_BITS-1:0] samples_in;
   logic [CFG_BITS-1:0] limit;
   logic                closes;
   logic                accept;
   logic                busy;
   logic [NUM_PINS-1:0] pin_bits;
   lane_flags_type [NUM_PINS-1:0] flags;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff  <= WINDOW_LENGTH_RESET;
         on_threshold_ff   <= ON_THRESHOLD_RESET;
         half_threshold_ff <= HALF_THRESHOLD_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_WINDOW_LENGTH:  window_length_ff  <= csr_data;
            REG_ON_THRESHOLD:   on_threshold_ff   <= csr_data;
            REG_HALF_THRESHOLD: half_threshold_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // The window decision depends only on state, so the stall is known
   // before the next word arrives.
   always_comb begin
      samples_in = samples_ff + CFG_BITS'(1);
      limit      = (window_length_ff == '0) ? CFG_BITS'(1) : window_length_ff;
      closes     = samples_in >= limit;
   end

   assign req_stall = busy && closes;
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         samples_ff <= '0;
      end else if (accept) begin
         samples_ff <= closes ? '0 : samples_in;
      end
   end

   assign pin_bits = {req_port_c_sample[3:0], req_port_b_sample[5:0],
                      req_port_a_sample[7:2]};

   for (genvar g = 0; g < NUM_PINS; g++) begin : g_lane
      wmiq_lane u_lane (
         .clock          (clock),
         .reset          (reset),
         .sample_bit     (pin_bits[g]),
         .advance        (accept),
         .clear          (closes),
         .on_threshold   (on_threshold_ff),
         .half_threshold (half_threshold_ff),
         .flags          (flags[g])
      );
   end

   wmiq_merge u_merge (
      .clock          (clock),
      .reset          (reset),
      .load           (accept && closes),
      .flags          (flags),
      .busy           (busy),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_frame_byte (rsp_frame_byte),
      .rsp_last_byte  (rsp_last_byte)
   );

endmodule

// File: sv/wmiq_lane.sv
`timescale 1ns / 1ps

module wmiq_lane (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             sample_bit,
   input  logic                             advance,
   input  logic                             clear,
   input  logic [wmiq_pkg::CFG_BITS-1:0]    on_threshold,
   input  logic [wmiq_pkg::CFG_BITS-1:0]    half_threshold,
   output wmiq_pkg::lane_flags_type         flags
);
   import wmiq_pkg::*;

   logic [COUNT_BITS-1:0] count_ff;
   logic [COUNT_BITS-1:0] count_in;

   // The count saturates instead of wrapping.
   always_comb begin
      if (sample_bit && (count_ff != COUNT_MAX)) begin
         count_in = count_ff + COUNT_BITS'(1);
      end else begin
         count_in = count_ff;
      end
      flags.on         = CMP_BITS'(count_in) > CMP_BITS'(on_threshold);
      flags.above_half = CMP_BITS'(count_in) > CMP_BITS'(half_threshold);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (advance) begin
         count_ff <= clear ? '0 : count_in;
      end
   end

endmodule

// File: sv/wmiq_merge.sv
`timescale 1ns / 1ps

module wmiq_merge (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        load,
   input  wmiq_pkg::lane_flags_type [wmiq_pkg::NUM_PINS-1:0] flags,
   output logic                                        busy,
   output logic                                        rsp_valid,
   input  logic                                        rsp_stall,
   output logic [7:0]                                  rsp_frame_byte,
   output logic                                        rsp_last_byte
);
   import wmiq_pkg::*;

   logic [7:0]     frame_ff [NUM_BYTES];
   logic [7:0]     frame_in [NUM_BYTES];
   logic           frame_valid_ff;
   logic           frame_valid_in;
   frame_slot_type slot_ff;
   frame_slot_type slot_in;
   logic           taken;
   logic [1:0]     level_c2;
   logic [1:0]     level_c3;

   function automatic logic [1:0] valve_level(lane_flags_type f);
      if (f.on) begin
         return LEVEL_ON;
      end else if (f.above_half) begin
         return LEVEL_HALF;
      end
      return LEVEL_OFF;
   endfunction

   always_comb begin
      level_c2 = valve_level(flags[14]);
      level_c3 = valve_level(flags[15]);
      frame_in[0] = {SLOT_0, flags[5].on, flags[4].on, flags[3].on,
                     flags[2].on, flags[1].on, flags[0].on};
      // Port B pins go out in the order the receiving side expects.
      frame_in[1] = {SLOT_1, flags[6].on, flags[9].on, flags[8].on,
                     flags[7].on, flags[10].on, flags[11].on};
      frame_in[2] = {SLOT_2, level_c3, level_c2, flags[13].on, flags[12].on};
   end

   assign taken = frame_valid_ff && !rsp_stall;

   always_comb begin
      slot_in        = slot_ff;
      frame_valid_in = frame_valid_ff;
      rsp_frame_byte = frame_ff[0];
      rsp_last_byte  = 1'b0;
      unique case (slot_ff)
         SLOT_0: begin
            rsp_frame_byte = frame_ff[0];
            if (taken) slot_in = SLOT_1;
         end
         SLOT_1: begin
            rsp_frame_byte = frame_ff[1];
            if (taken) slot_in = SLOT_2;
         end
         SLOT_2: begin
            rsp_frame_byte = frame_ff[2];
            rsp_last_byte  = 1'b1;
            if (taken) begin
               slot_in        = SLOT_0;
               frame_valid_in = 1'b0;
            end
         end
         default: begin
            slot_in = SLOT_0;
         end
      endcase
      if (load) begin
         frame_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff        <= SLOT_0;
         frame_valid_ff <= 1'b0;
      end else begin
         slot_ff        <= slot_in;
         frame_valid_ff <= frame_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         for (int i = 0; i < NUM_BYTES; i++) begin
            frame_ff[i] <= frame_in[i];
         end
      end
   end

   // The frame register frees up at the edge that takes the last word, so a
   // new frame can load at that same edge.
   assign busy      = frame_valid_ff && !(taken && (slot_ff == SLOT_2));
   assign rsp_valid = frame_valid_ff;

endmodule

// File: sv/wmiq_checker.sv
`timescale 1ns / 1ps

`include "windowed_majority_input_qualifier_top_assert.svh"

module wmiq_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_frame_byte,
   input logic       rsp_last_byte
);
   import wmiq_pkg::*;

   `WMIQ_ASSERT_NXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_frame_byte) && $stable(rsp_last_byte), "stalled response word changed")
   `WMIQ_ASSERT_IMP(a_last_matches_id, rsp_valid, rsp_last_byte == (rsp_frame_byte[7:6] == SLOT_2), "last flag does not match frame id")
   `WMIQ_ASSERT_NXT(a_frame_order, rsp_valid && !rsp_stall && !rsp_last_byte, rsp_valid && (rsp_frame_byte[7:6] == $past(rsp_frame_byte[7:6]) + 2'd1), "frame bytes out of order")
   `WMIQ_ASSERT_NXT(a_frame_restart, rsp_valid && !rsp_stall && rsp_last_byte, !rsp_valid || (rsp_frame_byte[7:6] == SLOT_0), "new frame does not start at byte zero")

endmodule

bind windowed_majority_input_qualifier_top wmiq_checker u_wmiq_checker (.*);
